/* rtl/etok_pkg.sv */
// Shared types, constants, character tables and helpers of the expression tokenizer
`timescale 1ns / 1ps

package etok_pkg;

  localparam int unsigned TEXT_BYTES_DEFAULT  = 65536;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;
  localparam int unsigned SLOTS               = 3;
  localparam int unsigned KW_COUNT            = 5;
  localparam int unsigned OP_CHAR_COUNT       = 11;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    KIND_NUMBER   = 4'd0,
    KIND_IDENT    = 4'd1,
    KIND_OPERATOR = 4'd2,
    KIND_RETURN   = 4'd3,
    KIND_IF       = 4'd4,
    KIND_ELSE     = 4'd5,
    KIND_WHILE    = 4'd6,
    KIND_FOR      = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } token_kind_t;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LT     = 4'd7;
  localparam logic [3:0] OP_GT     = 4'd8;
  localparam logic [3:0] OP_ASSIGN = 4'd9;
  localparam logic [3:0] OP_LE     = 4'd11;
  localparam logic [3:0] OP_GE     = 4'd12;
  localparam logic [3:0] OP_EQ     = 4'd13;
  localparam logic [3:0] OP_NE     = 4'd14;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_PENDING,
    MODE_DRAIN
  } scan_mode_t;

  typedef enum logic [1:0] {
    PEND_LT,
    PEND_GT,
    PEND_EQ,
    PEND_BANG
  } pend_op_t;

  typedef struct packed {
    token_kind_t  kind;
    logic [3:0]   op;
    logic [15:0]  start;
    logic [15:0]  length;
    logic [30:0]  value;
  } token_t;

  typedef struct packed {
    logic [SLOTS-1:0]   mask;
    token_t [SLOTS-1:0] slot;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_head_t;

  typedef struct packed {
    logic       found;
    logic [3:0] code;
  } op_hit_t;

  localparam logic [7:0] OP_CHARS [OP_CHAR_COUNT] = '{
    "(", ")", "+", "-", "*", "/", "%", "<", ">", "=", ";"
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd2, 3'd4, 3'd5, 3'd3};

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic op_hit_t op_lookup(logic [7:0] c);
    op_hit_t hit;
    hit = '{found: 1'b0, code: OP_NONE};
    for (int i = 0; i < OP_CHAR_COUNT; i++) begin
      if (OP_CHARS[i] == c) begin
        hit.found = 1'b1;
        hit.code  = 4'(i);
      end
    end
    return hit;
  endfunction

  function automatic logic [KW_COUNT-1:0] kw_match(logic [7:0] c, logic [15:0] idx,
                                                   logic [KW_COUNT-1:0] cur);
    logic [KW_COUNT-1:0] res;
    res = '0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cur[k] && idx < 16'(KW_LEN[k]) && KW_TEXT[k][idx[2:0]] == c) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic token_kind_t kw_kind(logic [KW_COUNT-1:0] cand, logic [15:0] len);
    token_kind_t kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand[k] && len == 16'(KW_LEN[k])) begin
        kind = token_kind_t'(4'(KIND_RETURN) + 4'(k));
      end
    end
    return kind;
  endfunction

  function automatic token_t make_tok(token_kind_t kind, logic [3:0] op, logic [15:0] start,
                                     logic [15:0] length, logic [30:0] value);
    token_t t;
    t.kind   = kind;
    t.op     = op;
    t.start  = start;
    t.length = length;
    t.value  = value;
    return t;
  endfunction

endpackage

/* rtl/etok_if.sv */
// Valid/ready channel interfaces for source bytes and tokens
`timescale 1ns / 1ps

interface etok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_final;

  modport source (output valid, char_byte, is_final, input ready);
  modport sink   (input valid, char_byte, is_final, output ready);
endinterface

interface etok_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  op_code;
  logic [15:0] start_offset;
  logic [15:0] token_length;
  logic [30:0] number_value;
  logic        last_of_run;

  modport source (output valid, token_kind, op_code, start_offset, token_length,
                  number_value, last_of_run, input ready);
  modport sink   (input valid, token_kind, op_code, start_offset, token_length,
                  number_value, last_of_run, output ready);
endinterface

/* rtl/etok_front.sv */
// Scanner front end: classifies each byte and builds the bundle of tokens it causes
`timescale 1ns / 1ps

module etok_front #(
  parameter int unsigned MAX_TEXT_BYTES = etok_pkg::TEXT_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  etok_char_if.sink         chars,
  input  logic              q_full,
  output logic              q_push,
  output etok_pkg::bundle_t q_data
);
  import etok_pkg::*;

  localparam logic [15:0] OFFSET_LIMIT =
    (MAX_TEXT_BYTES - 1 > 65535) ? 16'hFFFF : 16'(MAX_TEXT_BYTES - 1);

  typedef struct packed {
    logic       valid;
    token_t     tok;
    scan_mode_t mode;
  } flush_t;

  scan_mode_t          scan_mode, scan_mode_next;
  logic [15:0]         byte_offset, byte_offset_next;
  logic [15:0]         token_start, token_start_next;
  logic [30:0]         number_acc, number_acc_next;
  logic [KW_COUNT-1:0] kw_cand, kw_cand_next;
  pend_op_t            pend_op, pend_op_next;

  logic [7:0]          c;
  logic                fin;
  logic                fire;
  logic                used;
  logic                tok_a_valid, tok_b_valid;
  token_t              tok_a, tok_b;
  scan_mode_t          mode_a, mode_b;
  logic [KW_COUNT-1:0] cand_a, cand_b;
  logic [30:0]         acc_a, acc_b, acc_step;
  logic [15:0]         ts_b;
  pend_op_t            pend_b;
  flush_t              fa, fc;
  op_hit_t             hit;
  logic [34:0]         acc_sum;

  function automatic logic [3:0] pend_single(pend_op_t p);
    logic [3:0] code;
    unique case (p)
      PEND_LT: code = OP_LT;
      PEND_GT: code = OP_GT;
      PEND_EQ: code = OP_ASSIGN;
      PEND_BANG: code = OP_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] pend_pair(pend_op_t p);
    logic [3:0] code;
    unique case (p)
      PEND_LT: code = OP_LE;
      PEND_GT: code = OP_GE;
      PEND_EQ: code = OP_EQ;
      PEND_BANG: code = OP_NE;
    endcase
    return code;
  endfunction

  function automatic flush_t flush_tok(scan_mode_t mode, logic [15:0] ts, logic [16:0] endpos,
                                       logic [KW_COUNT-1:0] cand, logic [30:0] acc,
                                       pend_op_t pend);
    flush_t      f;
    logic [16:0] d;
    logic [15:0] len;
    d       = endpos - {1'b0, ts};
    len     = d[16] ? 16'hFFFF : d[15:0];
    f.valid = 1'b0;
    f.mode  = mode;
    f.tok   = make_tok(KIND_IDENT, OP_NONE, ts, len, '0);
    unique case (mode)
      MODE_IDENT: begin
        f.valid    = 1'b1;
        f.tok.kind = kw_kind(cand, len);
        f.mode     = MODE_IDLE;
      end
      MODE_NUMBER: begin
        f.valid     = 1'b1;
        f.tok.kind  = KIND_NUMBER;
        f.tok.value = acc;
        f.mode      = MODE_IDLE;
      end
      MODE_PENDING: begin
        f.valid      = 1'b1;
        f.tok.length = 16'd1;
        if (pend == PEND_BANG) begin
          f.tok.kind = KIND_ERROR;
          f.mode     = MODE_DRAIN;
        end else begin
          f.tok.kind = KIND_OPERATOR;
          f.tok.op   = pend_single(pend);
          f.mode     = MODE_IDLE;
        end
      end
      MODE_IDLE, MODE_DRAIN: begin
      end
    endcase
    return f;
  endfunction

  assign c           = chars.char_byte;
  assign fin         = chars.is_final;
  assign chars.ready = !q_full;
  assign fire        = chars.valid && !q_full;

  assign acc_sum  = {1'b0, number_acc, 3'b000} + {3'b000, number_acc, 1'b0} + 35'(c[3:0]);
  assign acc_step = (acc_sum > 35'(VALUE_MAX)) ? VALUE_MAX : acc_sum[30:0];

  // finish or extend the token in progress
  always_comb begin
    used        = 1'b0;
    tok_a_valid = 1'b0;
    tok_a       = make_tok(KIND_OPERATOR, OP_NONE, token_start, 16'd2, '0);
    mode_a      = scan_mode;
    cand_a      = kw_cand;
    acc_a       = number_acc;
    fa          = flush_tok(scan_mode, token_start, {1'b0, byte_offset}, kw_cand, number_acc,
                            pend_op);
    unique case (scan_mode)
      MODE_IDENT: begin
        if (is_letter(c) || is_digit(c)) begin
          cand_a = kw_match(c, byte_offset - token_start, kw_cand);
          used   = 1'b1;
        end else begin
          tok_a_valid = fa.valid;
          tok_a       = fa.tok;
          mode_a      = fa.mode;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          acc_a = acc_step;
          used  = 1'b1;
        end else begin
          tok_a_valid = fa.valid;
          tok_a       = fa.tok;
          mode_a      = fa.mode;
        end
      end
      MODE_PENDING: begin
        if (c == "=") begin
          tok_a_valid = 1'b1;
          tok_a.op    = pend_pair(pend_op);
          mode_a      = MODE_IDLE;
          used        = 1'b1;
        end else begin
          tok_a_valid = fa.valid;
          tok_a       = fa.tok;
          mode_a      = fa.mode;
        end
      end
      MODE_IDLE, MODE_DRAIN: begin
      end
    endcase
  end

  // start a new token on an unused byte
  always_comb begin
    hit         = op_lookup(c);
    mode_b      = mode_a;
    ts_b        = token_start;
    cand_b      = cand_a;
    acc_b       = acc_a;
    pend_b      = pend_op;
    tok_b_valid = 1'b0;
    tok_b       = make_tok(KIND_OPERATOR, hit.code, byte_offset, 16'd1, '0);
    if (!used && mode_a == MODE_IDLE) begin
      ts_b = byte_offset;
      priority if (is_space(c)) begin
      end else if (is_letter(c)) begin
        mode_b = MODE_IDENT;
        cand_b = kw_match(c, 16'd0, '1);
      end else if (is_digit(c)) begin
        mode_b = MODE_NUMBER;
        acc_b  = 31'(c[3:0]);
      end else if (c == "<") begin
        mode_b = MODE_PENDING;
        pend_b = PEND_LT;
      end else if (c == ">") begin
        mode_b = MODE_PENDING;
        pend_b = PEND_GT;
      end else if (c == "=") begin
        mode_b = MODE_PENDING;
        pend_b = PEND_EQ;
      end else if (c == "!") begin
        mode_b = MODE_PENDING;
        pend_b = PEND_BANG;
      end else if (hit.found) begin
        tok_b_valid = 1'b1;
      end else begin
        tok_b_valid = 1'b1;
        tok_b.kind  = KIND_ERROR;
        tok_b.op    = OP_NONE;
        mode_b      = MODE_DRAIN;
      end
    end
    fc = flush_tok(mode_b, ts_b, {1'b0, byte_offset} + 17'd1, cand_b, acc_b, pend_b);
  end

  // next state
  always_comb begin
    if (fin) begin
      scan_mode_next   = MODE_IDLE;
      byte_offset_next = '0;
      token_start_next = '0;
      number_acc_next  = '0;
      kw_cand_next     = '1;
      pend_op_next     = PEND_LT;
    end else begin
      scan_mode_next   = mode_b;
      byte_offset_next = (byte_offset < OFFSET_LIMIT) ? byte_offset + 16'd1 : OFFSET_LIMIT;
      token_start_next = ts_b;
      number_acc_next  = acc_b;
      kw_cand_next     = cand_b;
      pend_op_next     = pend_b;
    end
  end

  // bundle of tokens caused by this byte
  always_comb begin
    q_data.mask[0] = tok_a_valid;
    q_data.slot[0] = tok_a;
    q_data.mask[1] = tok_b_valid || (fin && fc.valid);
    q_data.slot[1] = tok_b_valid ? tok_b : fc.tok;
    q_data.mask[2] = fin;
    q_data.slot[2] = make_tok(KIND_END, OP_NONE, byte_offset, 16'd0, '0);
    q_push         = fire && (q_data.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= MODE_IDLE;
      byte_offset <= '0;
      token_start <= '0;
      number_acc  <= '0;
      kw_cand     <= '1;
      pend_op     <= PEND_LT;
    end else if (fire) begin
      scan_mode   <= scan_mode_next;
      byte_offset <= byte_offset_next;
      token_start <= token_start_next;
      number_acc  <= number_acc_next;
      kw_cand     <= kw_cand_next;
      pend_op     <= pend_op_next;
    end
  end

endmodule

/* rtl/etok_queue.sv */
// Short queue of token bundles between the scanner and the output stage
`timescale 1ns / 1ps

module etok_queue #(
  parameter int unsigned DEPTH = etok_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  etok_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output etok_pkg::q_head_t head
);
  import etok_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = count == CNT_W'(DEPTH);
  assign head.valid = count != '0;
  assign head.data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

/* rtl/etok_back.sv */
// Output stage: hands out the tokens of each bundle one transfer at a time
`timescale 1ns / 1ps

module etok_back (
  input  logic              clk,
  input  logic              rst,
  input  etok_pkg::q_head_t head,
  output logic              pop,
  etok_token_if.source      tokens
);
  import etok_pkg::*;

  logic [SLOTS-1:0] taken;
  logic [SLOTS-1:0] remaining;
  logic [SLOTS-1:0] sel;
  logic [SLOTS-1:0] rest;
  logic             load;
  token_t           sel_tok;
  token_t           out_tok;
  logic             out_valid;
  logic             out_last;

  always_comb begin
    remaining = head.data.mask & ~taken;
    sel       = remaining & (~remaining + SLOTS'(1));
    rest      = remaining & ~sel;
    load      = head.valid && (!out_valid || tokens.ready);
    pop       = load && (rest == '0);
    sel_tok   = head.data.slot[0];
    for (int i = 0; i < SLOTS; i++) begin
      if (sel[i]) begin
        sel_tok = head.data.slot[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      taken     <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      taken     <= pop ? '0 : (taken | sel);
    end else if (tokens.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok  <= sel_tok;
      out_last <= rest == '0;
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = out_tok.kind;
  assign tokens.op_code      = out_tok.op;
  assign tokens.start_offset = out_tok.start;
  assign tokens.token_length = out_tok.length;
  assign tokens.number_value = out_tok.value;
  assign tokens.last_of_run  = out_last;

endmodule

/* rtl/expression_tokenizer.sv */
// Top level of the expression tokenizer: scanner, bundle queue and output stage
// Path: an accepted byte's bundle is queued, then the output stage registers its first token.
// Throughput: one byte per cycle while the queue is not full; the output stage gives one token
// per cycle while tokens.ready is high, so a byte that ends in two or three tokens holds the
// output for one transfer each; the default two-entry queue lets the scanner run ahead.
// Reset: synchronous rst returns the scanner to idle at offset zero and empties the queue.
`timescale 1ns / 1ps

module expression_tokenizer #(
  parameter int unsigned MAX_TEXT_BYTES = etok_pkg::TEXT_BYTES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH    = etok_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  etok_char_if.sink    chars,
  etok_token_if.source tokens
);
  import etok_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  bundle_t q_data;
  q_head_t q_head;

  etok_front #(
    .MAX_TEXT_BYTES(MAX_TEXT_BYTES)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  etok_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  etok_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .pop    (q_pop),
    .tokens (tokens)
  );

endmodule

/* rtl/etok_checker.sv */
// Port-level checks on the token output of the tokenizer, bound to the top level
`timescale 1ns / 1ps

module etok_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [3:0]  token_kind,
  input logic [3:0]  op_code,
  input logic [15:0] start_offset,
  input logic [15:0] token_length,
  input logic [30:0] number_value,
  input logic        last_of_run
);
  import etok_pkg::*;

  a_reset_empties: assert property (@(posedge clk) rst |=> !valid)
    else $error("token output valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(token_kind) && $stable(op_code) &&
      $stable(start_offset) && $stable(token_length) && $stable(number_value) &&
      $stable(last_of_run))
    else $error("stalled token changed");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind == KIND_END |-> last_of_run && token_length == 16'd0)
    else $error("end token not last of its run or not empty");

  a_operator_length: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind == KIND_OPERATOR |->
      (op_code < OP_LE && token_length == 16'd1) ||
      (op_code >= OP_LE && op_code <= OP_NE && token_length == 16'd2))
    else $error("operator code does not match its length");

  a_plain_no_op: assert property (@(posedge clk) disable iff (rst)
    valid && token_kind != KIND_OPERATOR |-> op_code == OP_NONE)
    else $error("operator code on a non-operator token");

endmodule

bind expression_tokenizer etok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (tokens.valid),
  .ready        (tokens.ready),
  .token_kind   (tokens.token_kind),
  .op_code      (tokens.op_code),
  .start_offset (tokens.start_offset),
  .token_length (tokens.token_length),
  .number_value (tokens.number_value),
  .last_of_run  (tokens.last_of_run)
);
